// ===== rtl/caf_pkg.sv =====
// Shared types and constants for the counting admission filter.
// No dependencies; caf_slot_map, caf_sweep and the top level refer to it by scoped names.
`default_nettype none

package caf_pkg;

   // Default counter store depth
   localparam int DOOR_ENTRIES_DEF = 1024;

   // Field widths
   localparam int HASH_W    = 64;
   localparam int TIME_W    = 64;
   localparam int TOTAL_W   = 64;
   localparam int THRESH_W  = 8;
   localparam int PERIOD_W  = 32;
   localparam int CNT_W     = 8;
   localparam int KEY_HI_W  = 32;
   localparam int REQ_DATA_W = 128;
   localparam int RSP_DATA_W = 72;

   // Epoch tag stored beside each counter; a bulk clear bumps the epoch
   localparam int EPOCH_W = 8;

   localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

   // Register file
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 64;
   localparam logic [CSR_ADDR_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PERIOD    = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_START     = 2'd2;

   localparam logic [THRESH_W-1:0] THRESHOLD_RST = 8'd2;
   localparam logic [PERIOD_W-1:0] PERIOD_RST    = 32'd1000;
   localparam logic [TIME_W-1:0]   START_RST     = 64'd0;

   // One word of the counter store
   typedef struct packed {
      logic               vld;
      logic [EPOCH_W-1:0] tag;
      logic [CNT_W-1:0]   cnt;
   } door_word_type;

   localparam int WORD_W = $bits(door_word_type);

   // Sweep engine status toward the top level
   typedef struct packed {
      logic busy;   // hold off new transactions
      logic own;    // sweep drives the store ports
   } sweep_stat_type;

endpackage

`default_nettype wire

// ===== rtl/caf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the counter store of the admission filter.
`default_nettype none

module caf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/caf_slot_map.sv =====
// Counter index pipeline: (key_hash >> 32) mod DOOR_ENTRIES by reciprocal multiply.
// Depends on caf_pkg.
`default_nettype none

module caf_slot_map #(
   parameter int DOOR_ENTRIES = caf_pkg::DOOR_ENTRIES_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                adv,
   input  wire logic                                in_vld,
   input  wire logic [caf_pkg::KEY_HI_W-1:0]        in_key,
   input  wire logic [caf_pkg::TIME_W-1:0]          in_now,
   output logic                                     out_vld,
   output logic      [$clog2(DOOR_ENTRIES)-1:0]     out_slot,
   output logic      [caf_pkg::TIME_W-1:0]          out_now,
   output logic                                     busy
);

   localparam int IDX_W = $clog2(DOOR_ENTRIES);
   localparam logic [63:0] RECIP_FULL = 64'h1_0000_0000 / 64'(DOOR_ENTRIES);
   localparam logic [31:0] RECIP = RECIP_FULL[31:0];
   localparam logic [IDX_W:0] ENTRIES_N = (IDX_W+1)'(DOOR_ENTRIES);

   logic                          s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic [caf_pkg::KEY_HI_W-1:0]  s1_key_ff, s2_key_ff;
   logic [caf_pkg::TIME_W-1:0]    s1_now_ff, s2_now_ff, s3_now_ff;
   logic [31:0]                   s2_q_ff, s2_q_in;
   logic [IDX_W:0]                s3_rem_ff, s3_rem_in;
   logic [63:0]                   prod_q, prod_qn;
   logic [31:0]                   rem_full;
   logic [IDX_W:0]                rem_sub;

   // Quotient estimate is low by at most one, so the remainder stays below 2N
   assign prod_q    = 64'(s1_key_ff) * 64'(RECIP);
   assign s2_q_in   = prod_q[63:32];
   assign prod_qn   = 64'(s2_q_ff) * 64'(DOOR_ENTRIES);
   assign rem_full  = s2_key_ff - prod_qn[31:0];
   assign s3_rem_in = rem_full[IDX_W:0];
   assign rem_sub   = s3_rem_ff - ENTRIES_N;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= in_vld;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_key_ff <= in_key;
         s1_now_ff <= in_now;
         s2_key_ff <= s1_key_ff;
         s2_q_ff   <= s2_q_in;
         s2_now_ff <= s1_now_ff;
         s3_rem_ff <= s3_rem_in;
         s3_now_ff <= s2_now_ff;
      end
   end

   assign out_vld  = s3_vld_ff;
   assign out_now  = s3_now_ff;
   assign out_slot = (s3_rem_ff >= ENTRIES_N) ? rem_sub[IDX_W-1:0] : s3_rem_ff[IDX_W-1:0];
   assign busy     = s1_vld_ff | s2_vld_ff | s3_vld_ff;

endmodule

`default_nettype wire

// ===== rtl/caf_sweep.sv =====
// Counter store sweep: full invalidate after reset, and a periodic pass that
// retires stale epoch tags before the epoch counter wraps. Depends on caf_pkg.
`default_nettype none

module caf_sweep #(
   parameter int DOOR_ENTRIES = caf_pkg::DOOR_ENTRIES_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic                                pipe_empty,
   input  wire logic [caf_pkg::EPOCH_W-1:0]         epoch,
   input  wire caf_pkg::door_word_type              rd_word,
   output caf_pkg::sweep_stat_type                  stat,
   output logic                                     rd_en,
   output logic      [$clog2(DOOR_ENTRIES)-1:0]     rd_addr,
   output logic                                     wr_en,
   output logic      [$clog2(DOOR_ENTRIES)-1:0]     wr_addr,
   output caf_pkg::door_word_type                   wr_word
);

   localparam int IDX_W = $clog2(DOOR_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(DOOR_ENTRIES - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WAIT = 2'd1;
   localparam logic [1:0] ST_RUN  = 2'd2;

   logic [1:0]       st_ff, st_in;
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic             zap_all_ff, zap_all_in;
   logic             wr_vld_ff, wr_vld_in;
   logic [IDX_W-1:0] wr_addr_ff;
   logic             keep;

   always_comb begin
      st_in      = st_ff;
      addr_in    = addr_ff;
      zap_all_in = zap_all_ff;
      case (st_ff)
         ST_IDLE: begin
            if (start) begin
               st_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            // let transactions already in flight drain first
            if (pipe_empty) begin
               st_in      = ST_RUN;
               addr_in    = '0;
               zap_all_in = 1'b0;
            end
         end
         ST_RUN: begin
            addr_in = addr_ff + 1'b1;
            if (addr_ff == LAST_ADDR) begin
               st_in = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   assign wr_vld_in = (st_ff == ST_RUN);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= ST_RUN;
         addr_ff    <= '0;
         zap_all_ff <= 1'b1;
         wr_vld_ff  <= 1'b0;
      end else begin
         st_ff      <= st_in;
         addr_ff    <= addr_in;
         zap_all_ff <= zap_all_in;
         wr_vld_ff  <= wr_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff <= addr_ff;
   end

   // Keep entries of the live epoch, drop everything else
   assign keep    = ~zap_all_ff & rd_word.vld & (rd_word.tag == epoch);
   assign rd_en   = (st_ff == ST_RUN);
   assign rd_addr = addr_ff;
   assign wr_en   = wr_vld_ff & ~keep;
   assign wr_addr = wr_addr_ff;
   assign wr_word = '0;

   assign stat.busy = (st_ff != ST_IDLE) | wr_vld_ff;
   assign stat.own  = (st_ff == ST_RUN) | wr_vld_ff;

endmodule

`default_nettype wire

// ===== rtl/counting_admission_filter.sv =====
// Top level of the counting admission filter: request pipeline, counter update,
// window state and result register. Depends on caf_pkg, caf_ram, caf_slot_map, caf_sweep.
`default_nettype none

// One request per cycle in steady state; a request passes the input register, then two
// reciprocal-multiply stages for the counter index, the counter store read, then the
// result register. The whole pipeline stalls together while the result register is
// full and not taken. Counters are cleared in bulk by bumping an epoch tag kept
// beside each counter. After reset the block accepts no request while it invalidates
// the counter store; every 128 bulk clears it drains and sweeps the store again to
// retire stale tags. Configuration writes are taken at any time but belong in idle
// periods.
module counting_admission_filter #(
   parameter int DOOR_ENTRIES = caf_pkg::DOOR_ENTRIES_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // req_tdata: key_hash [63:0], now_ms [127:64]
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [caf_pkg::REQ_DATA_W-1:0]     req_tdata,
   // rsp_tdata: admitted [0], admit_total [64:1], zero [71:65]
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic      [caf_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  wire logic                               csr_wen,
   input  wire logic [caf_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  wire logic [caf_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int IDX_W = $clog2(DOOR_ENTRIES);

   // configuration
   logic [caf_pkg::THRESH_W-1:0] thresh_ff;
   logic [caf_pkg::PERIOD_W-1:0] period_ff;
   logic [caf_pkg::TIME_W-1:0]   start_ff;

   // window state
   logic [caf_pkg::TIME_W-1:0]   deadline_ff, deadline_in;
   logic [caf_pkg::EPOCH_W-1:0]  epoch_ff, epoch_in;
   logic [caf_pkg::TOTAL_W-1:0]  total_ff, total_in;

   // pipeline
   logic                         adv, accept;
   logic                         map_vld, map_busy;
   logic [IDX_W-1:0]             map_slot;
   logic [caf_pkg::TIME_W-1:0]   map_now;
   logic                         s4_vld_ff;
   logic [IDX_W-1:0]             s4_slot_ff;
   logic [caf_pkg::TIME_W-1:0]   s4_now_ff;

   // bypass of the store write that coincides with a read
   logic                         byp_vld_ff;
   logic [IDX_W-1:0]             byp_slot_ff;
   caf_pkg::door_word_type       byp_word_ff;

   // result register
   logic                         out_vld_ff;
   logic                         out_admit_ff, admit;
   logic [caf_pkg::TOTAL_W-1:0]  out_total_ff;

   // store ports
   caf_pkg::door_word_type       ram_rd, ram_wr, cur_word, item_word, sw_wr_word;
   logic                         ram_wr_en, ram_rd_en, item_wr, item_rd;
   logic [IDX_W-1:0]             ram_wr_addr, ram_rd_addr, sw_rd_addr, sw_wr_addr;
   logic                         sw_rd_en, sw_wr_en, sweep_start;
   caf_pkg::sweep_stat_type      sw_stat;

   // per-item update
   logic                         do_clear, live;
   logic [caf_pkg::CNT_W-1:0]    cnt0, cnt1, cnt_new;

   assign adv        = ~out_vld_ff | rsp_tready;
   assign req_tready = adv & ~sw_stat.busy;
   assign accept     = req_tvalid & req_tready;

   caf_slot_map #(
      .DOOR_ENTRIES(DOOR_ENTRIES)
   ) u_slot_map (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_vld  (accept),
      .in_key  (req_tdata[63:32]),
      .in_now  (req_tdata[127:64]),
      .out_vld (map_vld),
      .out_slot(map_slot),
      .out_now (map_now),
      .busy    (map_busy)
   );

   // ---------------------------------------------------------------- update
   assign cur_word = (byp_vld_ff && (byp_slot_ff == s4_slot_ff)) ? byp_word_ff : ram_rd;
   assign do_clear = (s4_now_ff >= deadline_ff);
   assign live     = cur_word.vld & (cur_word.tag == epoch_ff) & ~do_clear;
   assign cnt0     = live ? cur_word.cnt : '0;
   assign cnt1     = (cnt0 == caf_pkg::CNT_MAX) ? cnt0 : cnt0 + 1'b1;
   assign admit    = (cnt1 >= thresh_ff);
   assign cnt_new  = admit ? '0 : cnt1;
   assign epoch_in = do_clear ? epoch_ff + 1'b1 : epoch_ff;
   assign total_in = admit ? total_ff + 1'b1 : total_ff;

   assign item_word.vld = 1'b1;
   assign item_word.tag = epoch_in;
   assign item_word.cnt = cnt_new;

   assign item_wr = adv & s4_vld_ff;
   assign item_rd = adv & map_vld;

   // start a tag sweep each time the epoch lands on a half-range boundary
   assign sweep_start = item_wr & do_clear & (epoch_in[caf_pkg::EPOCH_W-2:0] == '0);

   // ---------------------------------------------------------------- store
   assign ram_wr_en   = sw_stat.own ? sw_wr_en   : item_wr;
   assign ram_wr_addr = sw_stat.own ? sw_wr_addr : s4_slot_ff;
   assign ram_wr      = sw_stat.own ? sw_wr_word : item_word;
   assign ram_rd_en   = sw_stat.own ? sw_rd_en   : item_rd;
   assign ram_rd_addr = sw_stat.own ? sw_rd_addr : map_slot;

   caf_ram #(
      .WIDTH(caf_pkg::WORD_W),
      .DEPTH(DOOR_ENTRIES)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd)
   );

   caf_sweep #(
      .DOOR_ENTRIES(DOOR_ENTRIES)
   ) u_sweep (
      .clock     (clock),
      .reset     (reset),
      .start     (sweep_start),
      .pipe_empty(~map_busy & ~s4_vld_ff),
      .epoch     (epoch_ff),
      .rd_word   (ram_rd),
      .stat      (sw_stat),
      .rd_en     (sw_rd_en),
      .rd_addr   (sw_rd_addr),
      .wr_en     (sw_wr_en),
      .wr_addr   (sw_wr_addr),
      .wr_word   (sw_wr_word)
   );

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff  <= 1'b0;
         byp_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         s4_vld_ff  <= map_vld;
         byp_vld_ff <= s4_vld_ff;
         out_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_slot_ff   <= map_slot;
         s4_now_ff    <= map_now;
         byp_slot_ff  <= s4_slot_ff;
         byp_word_ff  <= item_word;
         out_admit_ff <= admit;
         out_total_ff <= total_in;
      end
   end

   always_comb begin
      deadline_in = deadline_ff;
      if (item_wr && do_clear) begin
         deadline_in = s4_now_ff + caf_pkg::TIME_W'(period_ff);
      end
      if (csr_wen) begin
         case (csr_addr)
            caf_pkg::CSR_PERIOD: begin
               deadline_in = start_ff + caf_pkg::TIME_W'(csr_wdata[caf_pkg::PERIOD_W-1:0]);
            end
            caf_pkg::CSR_START: begin
               deadline_in = csr_wdata + caf_pkg::TIME_W'(period_ff);
            end
            default: begin
               // threshold and unknown writes leave the deadline alone
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff   <= caf_pkg::THRESHOLD_RST;
         period_ff   <= caf_pkg::PERIOD_RST;
         start_ff    <= caf_pkg::START_RST;
         deadline_ff <= caf_pkg::START_RST + caf_pkg::TIME_W'(caf_pkg::PERIOD_RST);
         epoch_ff    <= '0;
         total_ff    <= '0;
      end else begin
         deadline_ff <= deadline_in;
         if (item_wr) begin
            epoch_ff <= epoch_in;
            total_ff <= total_in;
         end
         if (csr_wen) begin
            case (csr_addr)
               caf_pkg::CSR_THRESHOLD: thresh_ff <= csr_wdata[caf_pkg::THRESH_W-1:0];
               caf_pkg::CSR_PERIOD:    period_ff <= csr_wdata[caf_pkg::PERIOD_W-1:0];
               caf_pkg::CSR_START:     start_ff  <= csr_wdata;
               default: begin
                  // unknown register: drop the write
               end
            endcase
         end
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {7'd0, out_total_ff, out_admit_ff};

endmodule

`default_nettype wire
